// ===== rtl/core/csb_pkg.sv =====
// Shared types and constants for the cross stencil height blur.
// No dependencies; imported by csb_div_stage and cross_stencil_height_blur.
`default_nettype none

package csb_pkg;

    // Default sizing
    localparam int MAX_WIDTH_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int CFG_W = 6;   // width register
    localparam int POS_W = 5;   // out_row / out_col

    // Divide-by-ten pipeline
    localparam int DIV_BPS   = 8;  // quotient bits resolved per stage
    localparam int DIV_REM_W = 4;  // partial remainder, always below the divisor
    localparam logic [DIV_REM_W-1:0] DIVISOR = 4'd10;

    // Rounding offset added before the floor division
    localparam int ROUND_OFS = 5;

    // Position and end-of-run tag that rides along with each result
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_tag;

endpackage

`default_nettype wire

// ===== rtl/core/csb_cell.sv =====
// One column cell of the line store chain: holds the middle and upper line
// sample for one column. Standalone, no package dependency.
`default_nettype none

module csb_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_shift,
    input  wire logic                          i_tail,
    input  wire logic signed [SAMPLE_BITS-1:0] i_ent_m,
    input  wire logic signed [SAMPLE_BITS-1:0] i_ent_u,
    input  wire logic signed [SAMPLE_BITS-1:0] i_nbr_m,
    input  wire logic signed [SAMPLE_BITS-1:0] i_nbr_u,
    output logic signed [SAMPLE_BITS-1:0]      o_m,
    output logic signed [SAMPLE_BITS-1:0]      o_u
);

    logic signed [SAMPLE_BITS-1:0] r_m;
    logic signed [SAMPLE_BITS-1:0] r_u;

    // tail cell takes the new entry, the rest take their upstream neighbour
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_m <= i_tail ? i_ent_m : i_nbr_m;
            r_u <= i_tail ? i_ent_u : i_nbr_u;
        end
    end

    assign o_m = r_m;
    assign o_u = r_u;

endmodule

`default_nettype wire

// ===== rtl/core/csb_div_stage.sv =====
// One stage of the divide-by-ten pipeline: resolves DIV_BPS quotient bits
// by long division on a narrow remainder. Depends on csb_pkg.
`default_nettype none

module csb_div_stage #(
    parameter int DW    = 24,
    parameter int STAGE = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire csb_pkg::t_tag        i_tag,
    input  wire logic [DW-1:0]        i_num,
    input  wire logic [DW-1:0]        i_quo,
    input  wire logic [csb_pkg::DIV_REM_W-1:0] i_rem,
    output logic                      o_valid,
    output csb_pkg::t_tag             o_tag,
    output logic [DW-1:0]             o_num,
    output logic [DW-1:0]             o_quo,
    output logic [csb_pkg::DIV_REM_W-1:0] o_rem
);

    import csb_pkg::*;

    localparam int TOP = DW - 1 - STAGE * DIV_BPS;

    logic [DIV_REM_W-1:0] n_rem;
    logic [DW-1:0]        n_quo;
    logic [DIV_REM_W:0]   trial;

    logic                 r_v;
    t_tag                 r_tag;
    logic [DW-1:0]        r_num;
    logic [DW-1:0]        r_quo;
    logic [DIV_REM_W-1:0] r_rem;

    // restoring long division, MSB first, remainder stays below ten
    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        trial = '0;
        for (int b = 0; b < DIV_BPS; b++) begin
            trial = {n_rem, i_num[TOP-b]};
            if (trial >= {1'b0, DIVISOR}) begin
                n_rem        = DIV_REM_W'(trial - {1'b0, DIVISOR});
                n_quo[TOP-b] = 1'b1;
            end else begin
                n_rem        = trial[DIV_REM_W-1:0];
                n_quo[TOP-b] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_num <= i_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_valid = r_v;
    assign o_tag   = r_tag;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_rem   = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/cross_stencil_height_blur.sv =====
// Five-point cross blur with edge clamp over a square height grid.
// Depends on csb_pkg, csb_cell and csb_div_stage.
//   Input channel (i_valid / o_stall / i_height): one signed height sample
//   per transfer, raster order over a W x W grid, W = i_cfg_wdata clamped
//   to 1..MAX_WIDTH (0 counts as 1). Writing the width restarts the grid.
//   Output channel (o_valid / i_stall): blurred value with its row, column
//   and o_run_last, which marks the final result caused by one input.
//   Throughput: one sample per cycle while o_stall is low. A sample in row r >= 1 releases the
//   result for row r-1 at the same column; row 0 releases nothing.
//   The last sample of the grid releases one result and then the whole
//   last row: o_stall is held while the column chain rotates once to
//   read that row out, and longer while the output is backed up.
//   Pipeline: a result passes the registered sum, then the NDS
//   divide-by-ten stages, NDS = ceil((SAMPLE_BITS+4)/8), then the
//   output register.
//   Stall: the output register is backed by a skid register, so one
//   result may wait while the pipeline keeps moving; while the skid is
//   full, the pipeline freezes and o_stall is high in the same cycle.
//   Reset (i_rst_n low, synchronous): width back to MAX_WIDTH, position
//   counters to zero, pipeline emptied. The line cells are not cleared.
`default_nettype none

module cross_stencil_height_blur #(
    parameter int MAX_WIDTH   = csb_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = csb_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [csb_pkg::CFG_W-1:0]       i_cfg_wdata,
    // sample in
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_height,
    // result out
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_blurred,
    output logic [csb_pkg::POS_W-1:0]            o_out_row,
    output logic [csb_pkg::POS_W-1:0]            o_out_col,
    output logic                                 o_run_last
);

    import csb_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // position counters
    localparam int SW  = SAMPLE_BITS + 5;                         // stencil sum, signed
    localparam int UW  = SAMPLE_BITS + 4;                         // biased sum, unsigned
    localparam int NDS = (UW + DIV_BPS - 1) / DIV_BPS;            // divider stages
    localparam int DW  = NDS * DIV_BPS;                           // padded dividend
    localparam int R1  = (MAX_WIDTH > 1) ? 1 : 0;                 // right-neighbour tap

    // sum + 5 + 10*2^(S-1) is never negative; the bias divides out exactly
    localparam logic [SW-1:0] BIAS = SW'(ROUND_OFS) << SAMPLE_BITS;
    localparam logic [SW-1:0] RND  = SW'(ROUND_OFS);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_wid;     // effective width, already clamped
    logic [CFG_W-1:0] wm1;
    logic [CW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic             r_burst;   // last-row read-out in progress
    logic [CW-1:0]    r_j;       // read-out column
    logic signed [SAMPLE_BITS-1:0] r_left;  // earlier row, previous column

    logic [CFG_W-1:0] n_wid;
    logic [CFG_W-1:0] row_ext;
    logic [CFG_W-1:0] col_ext;
    logic [CFG_W-1:0] j_ext;
    logic [CFG_W-1:0] row_m1;

    logic acc;     // input transfer this cycle
    logic bstep;   // one read-out step this cycle
    logic adv;     // pipeline moves
    logic fin;     // current sample closes the grid
    logic col_end;
    logic emit_n;  // transfer releases a result

    logic r_sk_v;

    assign wm1     = r_wid - CFG_W'(1);
    assign row_ext = CFG_W'(r_row);
    assign col_ext = CFG_W'(r_col);
    assign j_ext   = CFG_W'(r_j);
    assign row_m1  = row_ext - CFG_W'(1);

    assign adv     = !r_sk_v;
    assign o_stall = r_burst || r_sk_v;
    assign acc     = i_valid && !o_stall;
    assign bstep   = r_burst && adv;
    assign col_end = (col_ext == wm1);
    assign fin     = (row_ext == wm1) && col_end;
    assign emit_n  = acc && (r_row != '0);

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_wid = CFG_W'(1);
        end else if (i_cfg_wdata > CFG_W'(MAX_WIDTH)) begin
            n_wid = CFG_W'(MAX_WIDTH);
        end else begin
            n_wid = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid   <= CFG_W'(MAX_WIDTH);
            r_row   <= '0;
            r_col   <= '0;
            r_burst <= 1'b0;
            r_j     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wid <= n_wid;
                r_row <= '0;
                r_col <= '0;
            end else if (acc) begin
                if (fin) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (col_end) begin
                    r_col <= '0;
                    r_row <= r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            // last sample starts the row read-out
            if (acc && fin) begin
                r_burst <= 1'b1;
                r_j     <= '0;
            end else if (bstep) begin
                if (j_ext == wm1) begin
                    r_burst <= 1'b0;
                end
                r_j <= r_j + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Column cell chain. Cell 0 holds the column being filtered; the tail
    // cell (index W-1) takes the new entry on each shift, so the chain is
    // exactly W long. During read-out the chain rotates.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] m_q [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] u_q [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] ent_m;
    logic signed [SAMPLE_BITS-1:0] ent_u;
    logic                          shift;

    assign shift = acc || bstep;
    assign ent_m = bstep ? m_q[0] : i_height;
    assign ent_u = bstep ? u_q[0] : m_q[0];

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        logic tail;
        assign tail = (wm1 == CFG_W'(k));
        if (k == MAX_WIDTH - 1) begin : g_end
            csb_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_tail  (tail),
                .i_ent_m (ent_m),
                .i_ent_u (ent_u),
                .i_nbr_m (ent_m),
                .i_nbr_u (ent_u),
                .o_m     (m_q[k]),
                .o_u     (u_q[k])
            );
        end else begin : g_mid
            csb_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_tail  (tail),
                .i_ent_m (ent_m),
                .i_ent_u (ent_u),
                .i_nbr_m (m_q[k+1]),
                .i_nbr_u (u_q[k+1]),
                .o_m     (m_q[k]),
                .o_u     (u_q[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Stencil operands with edge clamp, then the biased sum
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] op_c, op_l, op_r, op_u, op_d;
    logic signed [SW-1:0]          e_c, e_l, e_r, e_u, e_d;
    logic [SW-1:0]                 sum;
    logic                          has_up, has_left, has_right;
    t_tag                          tag0;

    always_comb begin
        if (bstep) begin
            has_up    = (r_wid != CFG_W'(1));
            has_left  = (r_j != '0);
            has_right = (j_ext != wm1);
        end else begin
            has_up    = (row_ext >= CFG_W'(2));
            has_left  = (r_col != '0);
            has_right = !col_end;
        end
        op_c = m_q[0];
        op_u = has_up    ? u_q[0]  : op_c;
        op_l = has_left  ? r_left  : op_c;
        op_r = has_right ? m_q[R1] : op_c;
        op_d = bstep     ? op_c    : i_height;
    end

    assign e_c = SW'(op_c);
    assign e_l = SW'(op_l);
    assign e_r = SW'(op_r);
    assign e_u = SW'(op_u);
    assign e_d = SW'(op_d);
    assign sum = (e_c <<< 2) + (e_c <<< 1) + e_l + e_r + e_u + e_d + RND + BIAS;

    always_comb begin
        if (bstep) begin
            tag0.row  = wm1[POS_W-1:0];
            tag0.col  = j_ext[POS_W-1:0];
            tag0.last = (j_ext == wm1);
        end else begin
            tag0.row  = row_m1[POS_W-1:0];
            tag0.col  = col_ext[POS_W-1:0];
            tag0.last = !fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_n || bstep) begin
            r_left <= op_c;
        end
    end

    // stage 0: registered sum
    logic          r_s0_v;
    t_tag          r_s0_tag;
    logic [DW-1:0] r_s0_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (adv) begin
            r_s0_v <= emit_n || bstep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_tag <= tag0;
            r_s0_num <= DW'(sum[UW-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Divide by ten, DIV_BPS bits per stage
    // ------------------------------------------------------------------
    logic                 s_v   [NDS+1];
    t_tag                 s_tag [NDS+1];
    logic [DW-1:0]        s_num [NDS+1];
    logic [DW-1:0]        s_quo [NDS+1];
    logic [DIV_REM_W-1:0] s_rem [NDS+1];

    assign s_v[0]   = r_s0_v;
    assign s_tag[0] = r_s0_tag;
    assign s_num[0] = r_s0_num;
    assign s_quo[0] = '0;
    assign s_rem[0] = '0;

    for (genvar s = 0; s < NDS; s++) begin : g_div
        csb_div_stage #(
            .DW    (DW),
            .STAGE (s)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (s_v[s]),
            .i_tag   (s_tag[s]),
            .i_num   (s_num[s]),
            .i_quo   (s_quo[s]),
            .i_rem   (s_rem[s]),
            .o_valid (s_v[s+1]),
            .o_tag   (s_tag[s+1]),
            .o_num   (s_num[s+1]),
            .o_quo   (s_quo[s+1]),
            .o_rem   (s_rem[s+1])
        );
    end

    // quotient carries the bias 2^(S-1): flipping the top bit removes it
    logic [SAMPLE_BITS-1:0] quo_lo;
    logic signed [SAMPLE_BITS-1:0] res;
    logic push;

    assign quo_lo = s_quo[NDS][SAMPLE_BITS-1:0];
    assign res    = {~quo_lo[SAMPLE_BITS-1], quo_lo[SAMPLE_BITS-2:0]};
    assign push   = adv && s_v[NDS];

    // ------------------------------------------------------------------
    // Output register with skid
    // ------------------------------------------------------------------
    logic                          r_o_v;
    logic signed [SAMPLE_BITS-1:0] r_o_b;
    t_tag                          r_o_tag;
    logic signed [SAMPLE_BITS-1:0] r_sk_b;
    t_tag                          r_sk_tag;
    logic                          take;

    assign take = r_o_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (take) begin
                r_sk_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_o_v || take) begin
                r_o_v <= 1'b1;
            end else begin
                r_sk_v <= 1'b1;
            end
        end else if (take) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (take) begin
                r_o_b   <= r_sk_b;
                r_o_tag <= r_sk_tag;
            end
        end else if (push) begin
            if (!r_o_v || take) begin
                r_o_b   <= res;
                r_o_tag <= s_tag[NDS];
            end else begin
                r_sk_b   <= res;
                r_sk_tag <= s_tag[NDS];
            end
        end
    end

    assign o_valid    = r_o_v;
    assign o_blurred  = r_o_b;
    assign o_out_row  = r_o_tag.row;
    assign o_out_col  = r_o_tag.col;
    assign o_run_last = r_o_tag.last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid holds a result while the output register is empty");

    a_final_starts_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && fin) |=> r_burst)
        else $error("grid end did not start the last-row read-out");

    a_readout_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_burst) |-> ($past(j_ext) == $past(wm1)))
        else $error("last-row read-out ended before the row was complete");

    a_no_transfer_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstep |-> !emit_n && (tag0.row == wm1[POS_W-1:0]))
        else $error("input transfer overlapped the last-row read-out");

endmodule

`default_nettype wire
